>>> src/mts_pkg.sv
// Package of types, command codes and constant tables for the melody tone sequencer.
package mts_pkg;

	// Command codes carried on the command channel.
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_START   = 3'd1;
	localparam logic [2:0] CMD_STOP    = 3'd2;
	localparam logic [2:0] CMD_PLAY    = 3'd3;
	localparam logic [2:0] CMD_SILENCE = 3'd4;

	// Register map: a single register at word zero.
	localparam logic PADDR_WORD_PAUSE = 1'b0;
	localparam logic [7:0] PAUSE_MS_RESET = 8'd25;

	localparam int ROM_ENTRIES = 43;
	localparam logic [9:0] ELAPSED_MAX = 10'd1023;

	// PWM reload periods for C4 up to C5.
	localparam logic [11:0] TONE_PERIOD [8] = '{
		12'd2909, 12'd2591, 12'd2309, 12'd2180,
		12'd1941, 12'd1729, 12'd1541, 12'd1455
	};

	// Melody notes, one per entry.
	localparam logic [2:0] ROM_NOTE [ROM_ENTRIES] = '{
		3'd0, 3'd1, 3'd2, 3'd4, 3'd2, 3'd1, 3'd0,
		3'd2, 3'd4, 3'd5, 3'd7, 3'd6, 3'd4, 3'd2, 3'd3, 3'd2, 3'd1,
		3'd0, 3'd1, 3'd2, 3'd4, 3'd2, 3'd1, 3'd0, 3'd2, 3'd0,
		3'd2, 3'd5, 3'd6, 3'd7, 3'd6, 3'd4, 3'd2, 3'd3, 3'd2, 3'd1,
		3'd0, 3'd1, 3'd2, 3'd4, 3'd2, 3'd1, 3'd0
	};

	// Melody note durations in milliseconds.
	localparam logic [9:0] ROM_DUR [ROM_ENTRIES] = '{
		10'd300, 10'd300, 10'd450, 10'd600, 10'd450, 10'd450, 10'd600,
		10'd300, 10'd300, 10'd450, 10'd600, 10'd450, 10'd450, 10'd600,
		10'd150, 10'd150, 10'd600,
		10'd300, 10'd300, 10'd450, 10'd600, 10'd300, 10'd300, 10'd450,
		10'd300, 10'd600,
		10'd300, 10'd300, 10'd450, 10'd600, 10'd450, 10'd450, 10'd600,
		10'd150, 10'd150, 10'd600,
		10'd300, 10'd300, 10'd450, 10'd600, 10'd450, 10'd450, 10'd900
	};

	// One result item.
	typedef struct packed {
		logic [11:0] period;
		logic [10:0] compare;
		logic        restart_counter;
		logic        alarm_active;
		logic        in_pause;
		logic [5:0]  melody_position;
	} res_t;

	// Positions beyond the stored melody fold back onto it.
	function automatic logic [5:0] rom_index(input logic [5:0] pos);
		logic [5:0] idx;
		idx = (pos >= 6'(ROM_ENTRIES)) ? pos - 6'(ROM_ENTRIES) : pos;
		return idx;
	endfunction

endpackage

>>> src/mts_if.sv
// Channel interfaces for commands in and PWM settings out.
interface mts_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic [2:0] note;

	modport source (output valid, output command, output note, input ready);
	modport sink (input valid, input command, input note, output ready);
endinterface

interface mts_res_if;
	logic        valid;
	logic        ready;
	logic [11:0] period;
	logic [10:0] compare;
	logic        restart_counter;
	logic        alarm_active;
	logic        in_pause;
	logic [5:0]  melody_position;

	modport source (output valid, output period, output compare, output restart_counter,
		output alarm_active, output in_pause, output melody_position, input ready);
	modport sink (input valid, input period, input compare, input restart_counter,
		input alarm_active, input in_pause, input melody_position, output ready);
endinterface

>>> src/mts_skid.sv
// Two-entry output buffer that keeps results flowing while the receiver stalls.
module mts_skid
	import mts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  res_t in_data,
	output logic in_ready,
	output logic out_valid,
	output res_t out_data,
	input  logic out_ready
);

	logic out_valid_q;
	logic spare_valid_q;
	res_t out_data_q;
	res_t spare_data_q;
	logic out_free;

	// The head register may load when it is empty or being drained.
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = !spare_valid_q;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (out_free) begin
			if (spare_valid_q) begin
				out_valid_q   <= 1'b1;
				spare_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			spare_valid_q <= 1'b1;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= spare_valid_q ? spare_data_q : in_data;
		end else if (in_valid && in_ready) begin
			spare_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

>>> src/melody_tone_sequencer.sv
// Top level of the buzzer melody sequencer that produces PWM period and compare settings.
// Usage: each transfer on the cmd channel carries one command (tick of 1 ms, start alarm,
// stop alarm, play note, silence) and yields exactly one transfer on the res channel with
// the PWM period, compare value, counter restart flag and melody status.
// The pause between melody notes is set through the APB port at byte address 0; writes
// complete in the access cycle and pready is always high.
// Each result is registered in the result buffer before it is offered.
// Throughput: one command per cycle while cmd.ready is high; the state update is a
// single pass of ROM look-up, compares and counter updates before the result buffer.
// The result buffer holds two items, so one further command is taken while a result
// waits; cmd.ready is low while both entries hold results, which only a receiver stall
// brings about, and it rises again at the edge at which the receiver takes a result.
// At reset the alarm is off, position, period and compare are zero, the pause is 25 ms
// and the result buffer is empty.
module melody_tone_sequencer
	import mts_pkg::*;
#(
	parameter int MELODY_LENGTH = 43
) (
	input  logic        clk,
	input  logic        arst_n,
	mts_cmd_if.sink     cmd,
	mts_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0]  pause_ms_q;
	logic        alarm_on_q;
	logic        pausing_q;
	logic [9:0]  elapsed_q;
	logic [5:0]  pos_q;
	logic [11:0] period_q;
	logic [10:0] compare_q;

	logic        alarm_on_n;
	logic        pausing_n;
	logic [9:0]  elapsed_n;
	logic [5:0]  pos_n;
	logic [11:0] period_n;
	logic [10:0] compare_n;
	logic        restart_n;

	logic        cmd_xfer;
	logic [9:0]  elapsed_inc;
	logic [5:0]  pos_inc;
	logic [5:0]  pos_adv;
	logic [11:0] adv_period;
	logic        buf_ready;
	logic        res_valid;
	res_t        res_in;
	res_t        res_data;

	// APB register access.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == PADDR_WORD_PAUSE) ? {24'd0, pause_ms_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pause_ms_q <= PAUSE_MS_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == PADDR_WORD_PAUSE) begin
			pause_ms_q <= pwdata[7:0];
		end
	end

	assign cmd.ready = buf_ready;
	assign cmd_xfer  = cmd.valid && buf_ready;

	// Melody timing helpers.
	assign elapsed_inc = (elapsed_q < ELAPSED_MAX) ? elapsed_q + 10'd1 : elapsed_q;
	assign pos_inc     = pos_q + 6'd1;
	assign pos_adv     = ({1'b0, pos_inc} >= 7'(MELODY_LENGTH)) ? 6'd0 : pos_inc;
	assign adv_period  = TONE_PERIOD[ROM_NOTE[rom_index(pos_adv)]];

	// Next state for one command.
	always_comb begin
		alarm_on_n = alarm_on_q;
		pausing_n  = pausing_q;
		elapsed_n  = elapsed_q;
		pos_n      = pos_q;
		period_n   = period_q;
		compare_n  = compare_q;
		restart_n  = 1'b0;
		case (cmd.command)
			CMD_TICK: begin
				if (alarm_on_q) begin
					elapsed_n = elapsed_inc;
					if (!pausing_q) begin
						if (elapsed_inc >= ROM_DUR[rom_index(pos_q)]) begin
							compare_n = 11'd0;
							pausing_n = 1'b1;
							elapsed_n = 10'd0;
						end
					end else if (elapsed_inc >= {2'b00, pause_ms_q}) begin
						pos_n     = pos_adv;
						period_n  = adv_period;
						compare_n = adv_period[11:1];
						restart_n = 1'b1;
						pausing_n = 1'b0;
						elapsed_n = 10'd0;
					end
				end
			end
			CMD_START: begin
				alarm_on_n = 1'b1;
				pos_n      = 6'd0;
				pausing_n  = 1'b0;
				elapsed_n  = 10'd0;
				period_n   = TONE_PERIOD[ROM_NOTE[0]];
				compare_n  = TONE_PERIOD[ROM_NOTE[0]][11:1];
				restart_n  = 1'b1;
			end
			CMD_STOP: begin
				alarm_on_n = 1'b0;
				pausing_n  = 1'b0;
				compare_n  = 11'd0;
			end
			CMD_PLAY: begin
				period_n  = TONE_PERIOD[cmd.note];
				compare_n = TONE_PERIOD[cmd.note][11:1];
				restart_n = 1'b1;
			end
			CMD_SILENCE: begin
				compare_n = 11'd0;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_on_q <= 1'b0;
			pausing_q  <= 1'b0;
			elapsed_q  <= 10'd0;
			pos_q      <= 6'd0;
			period_q   <= 12'd0;
			compare_q  <= 11'd0;
		end else if (cmd_xfer) begin
			alarm_on_q <= alarm_on_n;
			pausing_q  <= pausing_n;
			elapsed_q  <= elapsed_n;
			pos_q      <= pos_n;
			period_q   <= period_n;
			compare_q  <= compare_n;
		end
	end

	// Result assembly and buffering.
	always_comb begin
		res_in.period          = period_n;
		res_in.compare         = compare_n;
		res_in.restart_counter = restart_n;
		res_in.alarm_active    = alarm_on_n;
		res_in.in_pause        = pausing_n;
		res_in.melody_position = pos_n;
	end

	mts_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_data   (res_in),
		.in_ready  (buf_ready),
		.out_valid (res_valid),
		.out_data  (res_data),
		.out_ready (res.ready)
	);

	assign res.valid           = res_valid;
	assign res.period          = res_data.period;
	assign res.compare         = res_data.compare;
	assign res.restart_counter = res_data.restart_counter;
	assign res.alarm_active    = res_data.alarm_active;
	assign res.in_pause        = res_data.in_pause;
	assign res.melody_position = res_data.melody_position;

	// A newly started tone always sounds at half its period.
	a_restart_half: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.restart_counter |-> res.compare == res.period[11:1])
		else $error("restarted tone without half-period compare");

	// The pause gap only exists while the alarm runs.
	a_pause_needs_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.in_pause |-> res.alarm_active)
		else $error("pause reported with alarm off");

	// The melody position never leaves the melody.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} < 7'(MELODY_LENGTH))
		else $error("melody position out of range");

	// A pause always starts from zero elapsed time.
	a_pause_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pausing_q) |-> elapsed_q == 10'd0)
		else $error("pause began with nonzero elapsed time");

endmodule
